FILE: src/dapt_pkg.sv
// Package for the divider and programmable timer.
// Holds register indexes, clock select codes, field widths and shared structs.
// No dependencies.
`default_nettype none

package dapt_pkg;

    localparam int unsigned ELAPSED_W = 3;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned FINE_W    = 4;
    localparam int unsigned APB_AW    = 4;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;

    // Register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_RELOAD = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_CSEL   = 2'd2;

    // Clock select codes
    localparam logic [1:0] CSEL_256 = 2'd0;
    localparam logic [1:0] CSEL_4   = 2'd1;
    localparam logic [1:0] CSEL_16  = 2'd2;
    localparam logic [1:0] CSEL_64  = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0] reload;
        logic             enable;
        logic [1:0]       csel;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  cycle;
        logic [CNT_W-1:0]  divider;
        logic [CNT_W-1:0]  timer;
        logic [FINE_W-1:0] fine;
    } t_state;

endpackage

`default_nettype wire

FILE: src/dapt_apb_regs.sv
// APB register file for the divider and programmable timer.
// Holds reload value, timer enable and clock select. Depends on dapt_pkg.
`default_nettype none

module dapt_apb_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_psel,
    input  wire logic                      i_penable,
    input  wire logic                      i_pwrite,
    input  wire logic [dapt_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [dapt_pkg::APB_DW-1:0] i_pwdata,
    output logic      [dapt_pkg::APB_DW-1:0] o_prdata,
    output dapt_pkg::t_cfg                 o_cfg
);
    import dapt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = i_psel & i_penable & i_pwrite;
    assign reg_idx = i_paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RELOAD: r_cfg.reload <= i_pwdata[CNT_W-1:0];
                REG_ENABLE: r_cfg.enable <= i_pwdata[0];
                REG_CSEL:   r_cfg.csel   <= i_pwdata[1:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RELOAD: o_prdata = APB_DW'(r_cfg.reload);
            REG_ENABLE: o_prdata = APB_DW'(r_cfg.enable);
            REG_CSEL:   o_prdata = APB_DW'(r_cfg.csel);
            default:    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/dapt_step.sv
// Next-state logic for one cycle report: cycle count, divider, timer and accumulator.
// Purely combinational. Depends on dapt_pkg.
`default_nettype none

module dapt_step (
    input  wire dapt_pkg::t_state               i_state,
    input  wire dapt_pkg::t_cfg                 i_cfg,
    input  wire logic [dapt_pkg::ELAPSED_W-1:0] i_elapsed,
    output dapt_pkg::t_state                    o_state,
    output logic                                o_irq
);
    import dapt_pkg::*;

    logic [CNT_W:0]    sum_full;
    logic [6:0]        sum_64;
    logic [4:0]        sum_16;
    logic [FINE_W-1:0] fine_sum;
    logic              cross_256;
    logic              cross_64;
    logic              cross_16;

    assign sum_full  = {1'b0, i_state.cycle} + (CNT_W+1)'(i_elapsed);
    assign sum_64    = {1'b0, i_state.cycle[5:0]} + 7'(i_elapsed);
    assign sum_16    = {1'b0, i_state.cycle[3:0]} + 5'(i_elapsed);
    assign cross_256 = sum_full[CNT_W];
    assign cross_64  = sum_64[6];
    assign cross_16  = sum_16[4];
    assign fine_sum  = i_state.fine + FINE_W'(i_elapsed);

    always_comb begin
        logic [1:0]       incs;
        logic [CNT_W-1:0] tmr;
        logic             irq;

        incs              = 2'd0;
        tmr               = i_state.timer;
        irq               = 1'b0;
        o_state.cycle     = sum_full[CNT_W-1:0];
        o_state.divider   = i_state.divider + CNT_W'(cross_64);
        o_state.fine      = i_state.fine;

        if (i_cfg.enable) begin
            o_state.fine = fine_sum;
            case (i_cfg.csel)
                CSEL_256: incs = 2'(cross_256);
                CSEL_4: begin
                    // drain whole groups of four, keep the remainder
                    incs         = fine_sum[3:2];
                    o_state.fine = {2'b00, fine_sum[1:0]};
                end
                CSEL_16:  incs = 2'(cross_16);
                default:  incs = 2'(cross_64);
            endcase
            // apply increments one at a time; each wrap reloads
            for (int k = 0; k < 3; k++) begin
                if (incs > 2'(k)) begin
                    if (tmr == {CNT_W{1'b1}}) begin
                        tmr = i_cfg.reload;
                        irq = 1'b1;
                    end else begin
                        tmr = tmr + CNT_W'(1);
                    end
                end
            end
        end

        o_state.timer = tmr;
        o_irq         = irq;
    end

endmodule

`default_nettype wire

FILE: src/divider_and_programmable_timer.sv
// Divider and programmable timer, top level.
// A result is loaded into the output register by the same edge that accepts its transaction.
// Throughput: one transaction per cycle; the single output register refills in the
// same cycle it drains, so input stalls only while the output is held back.
// Reset (i_rst_n, synchronous, active low) clears counters, config registers and valid; result payload is not reset.
// Depends on dapt_pkg, dapt_apb_regs and dapt_step.
`default_nettype none

module divider_and_programmable_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // cycle reports
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [dapt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [2:0] elapsed_cycles
    // results
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [dapt_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [7:0] div_out,
                                                              // [15:8] count_out,
                                                              // [16] irq_out
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dapt_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dapt_pkg::APB_DW-1:0]   pwdata,
    output logic      [dapt_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);
    import dapt_pkg::*;

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    logic              n_irq;
    logic              in_xfer;

    logic              r_out_valid;
    logic [CNT_W-1:0]  r_out_div;
    logic [CNT_W-1:0]  r_out_count;
    logic              r_out_irq;

    assign pready = 1'b1;

    dapt_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    // All arithmetic for a report settles between the state registers and
    // the output register.
    dapt_step u_step (
        .i_state   (r_state),
        .i_cfg     (cfg),
        .i_elapsed (s_axis_tdata[ELAPSED_W-1:0]),
        .o_state   (n_state),
        .o_irq     (n_irq)
    );

    // Accept whenever the output register is empty or drains this cycle.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Advance state only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload: load alongside the state, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_div   <= n_state.divider;
            r_out_count <= n_state.timer;
            r_out_irq   <= n_irq;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_irq, r_out_count, r_out_div};

    // An interrupt only comes from an enabled timer.
    a_irq_needs_enable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_irq) |-> cfg.enable)
        else $error("timer interrupt raised while timer disabled");

    // A disabled timer holds its count and accumulator.
    a_hold_when_off : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !cfg.enable) |=>
        (r_state.timer == $past(r_state.timer)) && (r_state.fine == $past(r_state.fine)))
        else $error("timer state moved while disabled");

    // Under the per-4 select the accumulator keeps only the remainder.
    a_fine_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && cfg.enable && (cfg.csel == CSEL_4)) |=> (r_state.fine[3:2] == 2'b00))
        else $error("accumulator not drained under per-4 select");

    // Result reported equals the state just committed.
    a_out_tracks_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_out_div == r_state.divider) && (r_out_count == r_state.timer))
        else $error("output register out of step with state");

endmodule

`default_nettype wire
